@@ hdl/time_series_linear_resampler_defines.svh @@
// assertion macros for the time series linear resampler
`ifndef TIME_SERIES_LINEAR_RESAMPLER_DEFINES_SVH
`define TIME_SERIES_LINEAR_RESAMPLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TSLR_ASSERT_IMPLY(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TSLR_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ hdl/tslr_pkg.sv @@
// shared types and constants of the time series linear resampler
package tslr_pkg;

  localparam int TIME_W  = 32;
  localparam int STEP_W  = 17;
  localparam int LEN_W   = 13;
  localparam int INDEX_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int MAX_RUN_DEF    = 64;
  localparam int VALUE_BITS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MODE  = 3'd4;

  localparam logic [TIME_W-1:0] START_RESET = 32'd0;
  localparam logic [STEP_W-1:0] STEP_RESET  = 17'd3600;
  localparam logic [LEN_W-1:0]  LEN_RESET   = 13'd4096;
  localparam int                THR_RESET   = -25600;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LO_GO,
    S_LO_WAIT,
    S_HI_GO,
    S_HI_WAIT,
    S_MUL,
    S_POINT,
    S_INT_WAIT,
    S_EMIT,
    S_FLUSH
  } tslr_state_t;

endpackage

@@ hdl/tslr_muldiv.sv @@
// bit-serial unit computing floor(n * a / d) for a <= d, one bit of n per cycle
module tslr_muldiv #(
  parameter int N_W = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [N_W-1:0]              n,
  input  logic [tslr_pkg::TIME_W-1:0] a,
  input  logic [tslr_pkg::TIME_W-1:0] d,
  output logic                        done,
  output logic [N_W-1:0]              q
);
  import tslr_pkg::*;

  localparam int IT_W = $clog2(N_W);

  logic              busy;
  logic [IT_W-1:0]   iter;
  logic [N_W-1:0]    n_sh;
  logic [TIME_W-1:0] a_reg;
  logic [TIME_W-1:0] d_reg;
  logic [TIME_W-1:0] rem;

  logic [TIME_W+1:0] sum;
  logic [TIME_W+1:0] d1;
  logic [TIME_W+1:0] d2;
  logic [TIME_W-1:0] rem_next;
  logic [1:0]        k;
  logic [N_W-1:0]    q_next;

  always_comb begin
    sum = {1'b0, rem, 1'b0} + (n_sh[N_W-1] ? {2'b00, a_reg} : '0);
    d1  = {2'b00, d_reg};
    d2  = {1'b0, d_reg, 1'b0};
    if (sum >= d2) begin
      rem_next = TIME_W'(sum - d2);
      k        = 2'd2;
    end else if (sum >= d1) begin
      rem_next = TIME_W'(sum - d1);
      k        = 2'd1;
    end else begin
      rem_next = TIME_W'(sum);
      k        = 2'd0;
    end
    q_next = {q[N_W-2:0], 1'b0} + N_W'(k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && iter == IT_W'(N_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_sh  <= n;
      a_reg <= a;
      d_reg <= d;
      rem   <= '0;
      q     <= '0;
      iter  <= '0;
    end else if (busy) begin
      n_sh <= {n_sh[N_W-2:0], 1'b0};
      rem  <= rem_next;
      q    <= q_next;
      iter <= iter + 1'b1;
    end
  end

endmodule

@@ hdl/time_series_linear_resampler.sv @@
// Time series linear resampler, top level.
// Raw samples enter on s_axis (tdata: sample_time, sample_value; tlast:
// final_sample) and grid points leave on m_axis (tdata: point_index,
// point_value; tlast: run_end; tuser: run_truncated). Registers are
// written on the cfg channel, ready whenever reset is low; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Each request runs two grid counts on the bit-serial mul-div unit
// (N bits wide, N = 32 for values up to 31 bits), a bit-serial index
// multiply, then visits each grid point, emits a result for each one not
// skipped and runs the mul-div unit once more per interpolated point. A
// run is cut to at most MAX_RUN = 64 grid points; a dropped request leaves the
// block idle. The last result of a request leaves through a one-deep
// holding stage so that run_end can be set.
// The output register lets s_axis take the next request while a result
// still waits; a stalled receiver holds the point loop only when a new
// result meets a full holding stage and output register.
// Reset clears the series state, restores the register defaults and holds
// off both input channels.
`include "time_series_linear_resampler_defines.svh"

module time_series_linear_resampler #(
  parameter int MAX_POINTS = tslr_pkg::MAX_POINTS_DEF,
  parameter int MAX_RUN    = tslr_pkg::MAX_RUN_DEF,
  parameter int VALUE_BITS = tslr_pkg::VALUE_BITS_DEF,
  localparam int IN_W  = ((tslr_pkg::TIME_W + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((tslr_pkg::INDEX_W + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tslr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tslr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // sample_time, sample_value
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,  // point_index, point_value
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser   // run_truncated
);
  import tslr_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int MC_W  = $clog2(CNT_W);
  localparam int VX_W  = VALUE_BITS + 1;
  localparam int N_W   = (VX_W > TIME_W) ? VX_W : TIME_W;

  // configuration
  logic [TIME_W-1:0]            grid_start_time;
  logic [STEP_W-1:0]            grid_step;
  logic [LEN_W-1:0]             grid_length;
  logic signed [VALUE_BITS-1:0] missing_threshold;
  logic                         hold_next_mode;

  // series state
  logic [TIME_W-1:0]            prev_time;
  logic signed [VALUE_BITS-1:0] prev_value;
  logic                         have_prev;
  logic [CNT_W-1:0]             next_point;

  // current request
  logic [TIME_W-1:0]            t_reg;
  logic signed [VALUE_BITS-1:0] v_reg;
  logic                         fin_reg;
  logic [CNT_W-1:0]             lo;
  logic [CNT_W-1:0]             hi;
  logic [CNT_W-1:0]             stop;
  logic [CNT_W-1:0]             p;
  logic                         trunc;
  logic [TIME_W-1:0]            g;
  logic [TIME_W-1:0]            acc;
  logic [CNT_W-1:0]             mul_sh;
  logic [MC_W-1:0]              mul_cnt;
  logic [VALUE_BITS-1:0]        res;

  // holding stage and output register
  logic                         pend_valid;
  logic [INDEX_W-1:0]           pend_index;
  logic [VALUE_BITS-1:0]        pend_value;
  logic                         out_valid;
  logic [INDEX_W-1:0]           out_index;
  logic [VALUE_BITS-1:0]        out_value;
  logic                         out_last;
  logic                         out_trunc;

  tslr_state_t state, state_next;

  // mul-div unit
  logic              md_start;
  logic              md_done;
  logic [N_W-1:0]    md_n;
  logic [TIME_W-1:0] md_a;
  logic [TIME_W-1:0] md_d;
  logic [N_W-1:0]    md_q;

  // datapath terms
  logic [TIME_W-1:0]            in_time;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         accept;
  logic                         drop;
  logic [STEP_W-1:0]            step_eff;
  logic [CNT_W-1:0]             len_eff;
  logic [TIME_W-1:0]            lo_x;
  logic                         lo_zero;
  logic                         hi_zero;
  logic                         cnt_zero;
  logic [CNT_W-1:0]             cnt_c;
  logic [CNT_W-1:0]             hi_m;
  logic [CNT_W-1:0]             span;
  logic                         trunc_c;
  logic [TIME_W-1:0]            acc_next;
  logic                         mul_last;
  logic                         at_end;
  logic                         exact;
  logic                         v_miss;
  logic                         pv_miss;
  logic                         use_v;
  logic                         skip;
  logic                         go_int;
  logic signed [VX_W-1:0]       diff;
  logic                         neg;
  logic [VX_W-1:0]              mag;
  logic signed [VX_W-1:0]       interp;
  logic                         slot_free;
  logic                         emit_ok;
  logic                         out_load;

  assign in_time  = s_axis_tdata[TIME_W-1:0];
  assign in_value = s_axis_tdata[TIME_W +: VALUE_BITS];

  assign cfg_ready = !rst;

  assign step_eff = (grid_step == '0) ? STEP_W'(1) : grid_step;
  assign len_eff  = (32'(grid_length) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                         : CNT_W'(grid_length);

  assign accept = s_axis_tvalid && s_axis_tready;
  assign drop   = have_prev && (in_time <= prev_time);

  assign lo_x    = have_prev ? prev_time : (t_reg - 1'b1);
  assign lo_zero = have_prev ? (prev_time < grid_start_time) : (t_reg <= grid_start_time);
  assign hi_zero = t_reg < grid_start_time;

  always_comb begin
    cnt_zero = (state == S_LO_WAIT) ? lo_zero : hi_zero;
    if (cnt_zero) begin
      cnt_c = '0;
    end else if (md_q >= N_W'(len_eff)) begin
      cnt_c = len_eff;
    end else begin
      cnt_c = CNT_W'(md_q) + CNT_W'(1);
    end
    hi_m    = (cnt_c < lo) ? lo : cnt_c;
    span    = hi_m - lo;
    trunc_c = 32'(span) > 32'(MAX_RUN);
  end

  assign acc_next = {acc[TIME_W-2:0], 1'b0} + (mul_sh[CNT_W-1] ? TIME_W'(step_eff) : '0);
  assign mul_last = mul_cnt == MC_W'(CNT_W - 1);

  assign at_end  = p == stop;
  assign exact   = g == t_reg;
  assign v_miss  = v_reg <= missing_threshold;
  assign pv_miss = prev_value <= missing_threshold;
  assign use_v   = exact || hold_next_mode;
  assign skip    = use_v ? v_miss : (v_miss || pv_miss);
  assign go_int  = !at_end && !skip && !use_v;

  always_comb begin
    diff   = VX_W'(v_reg) - VX_W'(prev_value);
    neg    = diff[VX_W-1];
    mag    = neg ? VX_W'(-diff) : VX_W'(diff);
    interp = neg ? (VX_W'(prev_value) - signed'(md_q[VX_W-1:0]))
                 : (VX_W'(prev_value) + signed'(md_q[VX_W-1:0]));
  end

  always_comb begin
    case (state)
      S_LO_GO: begin
        md_n = N_W'(lo_x - grid_start_time);
        md_a = TIME_W'(1);
        md_d = TIME_W'(step_eff);
      end
      S_HI_GO: begin
        md_n = N_W'(t_reg - grid_start_time);
        md_a = TIME_W'(1);
        md_d = TIME_W'(step_eff);
      end
      default: begin
        md_n = N_W'(mag);
        md_a = g - prev_time;
        md_d = t_reg - prev_time;
      end
    endcase
  end

  assign slot_free = !out_valid || m_axis_tready;
  assign emit_ok   = !pend_valid || slot_free;

  tslr_muldiv #(
    .N_W(N_W)
  ) u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .start(md_start),
    .n    (md_n),
    .a    (md_a),
    .d    (md_d),
    .done (md_done),
    .q    (md_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (accept && !drop) state_next = S_LO_GO;
      S_LO_GO:    state_next = S_LO_WAIT;
      S_LO_WAIT:  if (md_done) state_next = S_HI_GO;
      S_HI_GO:    state_next = S_HI_WAIT;
      S_HI_WAIT:  if (md_done) state_next = S_MUL;
      S_MUL:      if (mul_last) state_next = S_POINT;
      S_POINT: begin
        if (at_end) begin
          state_next = S_FLUSH;
        end else if (!skip) begin
          state_next = use_v ? S_EMIT : S_INT_WAIT;
        end
      end
      S_INT_WAIT: if (md_done) state_next = S_EMIT;
      S_EMIT:     if (emit_ok) state_next = S_POINT;
      S_FLUSH:    if (emit_ok) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    s_axis_tready = 1'b0;
    md_start      = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE:   s_axis_tready = !rst;
      S_LO_GO:  md_start = 1'b1;
      S_HI_GO:  md_start = 1'b1;
      S_POINT:  md_start = go_int;
      S_EMIT:   out_load = pend_valid && slot_free;
      S_FLUSH:  out_load = pend_valid && slot_free;
      default:  md_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_start_time   <= START_RESET;
      grid_step         <= STEP_RESET;
      grid_length       <= LEN_RESET;
      missing_threshold <= VALUE_BITS'(THR_RESET);
      hold_next_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_START: grid_start_time   <= cfg_data[TIME_W-1:0];
        REG_GRID_STEP:  grid_step         <= cfg_data[STEP_W-1:0];
        REG_GRID_LEN:   grid_length       <= cfg_data[LEN_W-1:0];
        REG_MISS_THR:   missing_threshold <= cfg_data[VALUE_BITS-1:0];
        REG_HOLD_MODE:  hold_next_mode    <= cfg_data[0];
        default:        hold_next_mode    <= hold_next_mode;
      endcase
    end
  end

  // series state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time  <= '0;
      prev_value <= '0;
      have_prev  <= 1'b0;
      next_point <= '0;
    end else if (state == S_IDLE && accept && drop) begin
      if (s_axis_tlast) begin
        have_prev  <= 1'b0;
        next_point <= '0;
      end
    end else if (state == S_FLUSH && emit_ok) begin
      prev_time  <= t_reg;
      prev_value <= v_reg;
      have_prev  <= !fin_reg;
      next_point <= fin_reg ? '0 : hi;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          t_reg   <= in_time;
          v_reg   <= in_value;
          fin_reg <= s_axis_tlast;
        end
      end
      S_LO_WAIT: begin
        if (md_done) lo <= (cnt_c < next_point) ? next_point : cnt_c;
      end
      S_HI_WAIT: begin
        if (md_done) begin
          hi      <= hi_m;
          trunc   <= trunc_c;
          stop    <= trunc_c ? (lo + CNT_W'(MAX_RUN)) : hi_m;
          p       <= lo;
          mul_sh  <= lo;
          mul_cnt <= '0;
          acc     <= '0;
        end
      end
      S_MUL: begin
        acc     <= acc_next;
        mul_sh  <= {mul_sh[CNT_W-2:0], 1'b0};
        mul_cnt <= mul_cnt + 1'b1;
        if (mul_last) g <= acc_next + grid_start_time;
      end
      S_POINT: begin
        if (!at_end && skip) begin
          p <= p + 1'b1;
          g <= g + TIME_W'(step_eff);
        end else if (!at_end && use_v) begin
          res <= v_reg;
        end
      end
      S_INT_WAIT: begin
        if (md_done) res <= interp[VALUE_BITS-1:0];
      end
      S_EMIT: begin
        if (emit_ok) begin
          pend_index <= INDEX_W'(p);
          pend_value <= res;
          p          <= p + 1'b1;
          g          <= g + TIME_W'(step_eff);
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

  // holding stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_EMIT && emit_ok) begin
        pend_valid <= 1'b1;
      end else if (state == S_FLUSH && emit_ok) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= pend_index;
      out_value <= pend_value;
      out_last  <= state == S_FLUSH;
      out_trunc <= trunc;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_value, out_index});
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_trunc;

  `TSLR_ASSERT_IMPLY(a_done_in_wait, md_done,
    state == S_LO_WAIT || state == S_HI_WAIT || state == S_INT_WAIT,
    "mul-div result arrived outside a wait state")

  `TSLR_ASSERT_IMPLY(a_point_bound, state == S_POINT || state == S_EMIT || state == S_INT_WAIT,
    p <= stop, "grid point ran past the end of the run")

  `TSLR_ASSERT_IMPLY(a_run_limit, state == S_POINT,
    32'(stop - lo) <= 32'(MAX_RUN), "run longer than the run limit")

  `TSLR_ASSERT_NEXT(a_drop_stays_idle, state == S_IDLE && accept && drop,
    state == S_IDLE, "dropped sample started a run")

endmodule
